/* hdl/lpm_pkg.sv */
// ============================================================================
// lpm_pkg
// Shared types and constants for the line prefix matcher: result kinds,
// configuration register indexes and the event record passed from the
// front end to the result queue.
// ============================================================================
package lpm_pkg;

    // default parameter values
    localparam int LPM_MAX_PREFIX  = 32;
    localparam int LPM_OFFSET_BITS = 32;

    // fixed field widths
    localparam int BYTE_W      = 8;
    localparam int OUT_OFF_W   = 32;
    localparam int COUNT_W     = 7;
    localparam int PLEN_W      = 6;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int PREFIX_W    = 4 * CFG_DATA_W;
    localparam int BYTE_SEL_W  = 5;

    localparam logic [BYTE_W-1:0]  NEWLINE_BYTE      = 8'd10;
    localparam logic [COUNT_W-1:0] MATCH_LIMIT_RESET = 7'd127;

    // result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_MATCH    = 2'd0,
        KIND_DONE     = 2'd1,
        KIND_OVERFLOW = 2'd2
    } t_kind;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PREFIX_LENGTH = 3'd0,
        CFG_PREFIX_0_7    = 3'd1,
        CFG_PREFIX_8_15   = 3'd2,
        CFG_PREFIX_16_23  = 3'd3,
        CFG_PREFIX_24_31  = 3'd4,
        CFG_MATCH_LIMIT   = 3'd5
    } t_cfg_index;

    // one queue entry: the results caused by one byte
    typedef struct packed {
        t_kind                kind;
        logic [OUT_OFF_W-1:0] line_offset;
        logic [OUT_OFF_W-1:0] after_offset;
        logic [COUNT_W-1:0]   count;
        logic                 tail_done;   // a done result follows the first one
    } t_event;

endpackage

/* hdl/lpm_byte_if.sv */
// ============================================================================
// lpm_byte_if
// Dictionary byte channel: valid/ready handshake with byte and final flag.
// ============================================================================
interface lpm_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] dict_byte;
    logic       final_byte;

    modport source (output valid, output dict_byte, output final_byte, input ready);
    modport sink   (input valid, input dict_byte, input final_byte, output ready);
endinterface

/* hdl/lpm_result_if.sv */
// ============================================================================
// lpm_result_if
// Result channel: valid/ready handshake with kind, offsets and match count.
// ============================================================================
interface lpm_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [31:0] line_offset;
    logic [31:0] after_prefix_offset;
    logic [6:0]  matches_found;
    logic        last_of_run;

    modport source (
        output valid, output result_kind, output line_offset,
        output after_prefix_offset, output matches_found, output last_of_run,
        input  ready
    );
    modport sink (
        input  valid, input result_kind, input line_offset,
        input  after_prefix_offset, input matches_found, input last_of_run,
        output ready
    );
endinterface

/* hdl/line_prefix_matcher.sv */
// ============================================================================
// line_prefix_matcher
// Finds every newline-separated dictionary line that starts with a
// configured prefix and reports start and after-prefix offsets, a done
// count on the last byte, or an overflow once the match limit is passed.
//
//   channel   dir   handshake        payload
//   i_byte    in    valid/ready      dict_byte[7:0], final_byte
//   o_result  out   valid/ready      result_kind, line_offset, after_prefix_offset,
//                                    matches_found, last_of_run
//   cfg       in    write enable     i_cfg_index[2:0], i_cfg_wdata[63:0]
//
// One byte is accepted per cycle; its results enter a 4-entry queue at that
// edge and are offered from the next cycle on, one result item per cycle
// while o_result is ready. A byte with a match and a done result gives two
// items, match then done. Input ready drops only when the result queue is full.
// Reset is synchronous and clears search state and registers to defaults.
// ============================================================================
module line_prefix_matcher #(
    parameter int MAX_PREFIX  = lpm_pkg::LPM_MAX_PREFIX,
    parameter int OFFSET_BITS = lpm_pkg::LPM_OFFSET_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lpm_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [lpm_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    lpm_byte_if.sink                         i_byte,
    lpm_result_if.source                     o_result
);
    import lpm_pkg::*;

    logic   push;
    logic   pop;
    logic   full;
    logic   empty;
    t_event push_event;
    t_event head_event;

    // front end: configuration, byte classification
    lpm_front #(
        .MAX_PREFIX  (MAX_PREFIX),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_byte.valid),
        .i_dict_byte  (i_byte.dict_byte),
        .i_final_byte (i_byte.final_byte),
        .i_queue_full (full),
        .o_ready      (i_byte.ready),
        .o_push       (push),
        .o_event      (push_event)
    );

    // event queue
    lpm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_event (push_event),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head_event)
    );

    // result side
    lpm_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_head   (head_event),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule

/* hdl/lpm_front.sv */
// ============================================================================
// lpm_front
// Front end: holds the configuration registers and the search state, takes
// one byte per cycle while the result queue is not full, classifies it and
// pushes an event record into the result queue when the byte causes any result.
// ============================================================================
module lpm_front #(
    parameter int MAX_PREFIX  = lpm_pkg::LPM_MAX_PREFIX,
    parameter int OFFSET_BITS = lpm_pkg::LPM_OFFSET_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lpm_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [lpm_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                             i_valid,
    input  logic [lpm_pkg::BYTE_W-1:0]       i_dict_byte,
    input  logic                             i_final_byte,
    input  logic                             i_queue_full,
    output logic                             o_ready,
    output logic                             o_push,
    output lpm_pkg::t_event                  o_event
);
    import lpm_pkg::*;

    localparam int IDX_W = $clog2(MAX_PREFIX + 1);
    localparam logic [PLEN_W-1:0] MAX_PLEN = PLEN_W'(MAX_PREFIX);

    // configuration registers
    logic [PLEN_W-1:0]   r_plen;
    logic [PREFIX_W-1:0] r_prefix;
    logic [COUNT_W-1:0]  r_limit;

    // search state
    logic [OFFSET_BITS-1:0] r_offset, n_offset;
    logic [OFFSET_BITS-1:0] r_line, n_line;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic                   r_still, n_still;
    logic [COUNT_W-1:0]     r_count, n_count;
    logic                   r_ovf, n_ovf;

    logic                   accept;
    logic [PLEN_W-1:0]      plen;
    logic [PLEN_W-1:0]      idx_ext;
    logic [BYTE_SEL_W-1:0]  byte_sel;
    logic [BYTE_W-1:0]      pbyte;
    logic [OFFSET_BITS-1:0] pos_inc;
    logic [OFFSET_BITS+OUT_OFF_W-1:0] line_wide, pos_wide;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen   <= '0;
            r_prefix <= '0;
            r_limit  <= MATCH_LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PREFIX_LENGTH: r_plen <= i_cfg_wdata[PLEN_W-1:0];
                CFG_PREFIX_0_7:    r_prefix[0*CFG_DATA_W +: CFG_DATA_W] <= i_cfg_wdata;
                CFG_PREFIX_8_15:   r_prefix[1*CFG_DATA_W +: CFG_DATA_W] <= i_cfg_wdata;
                CFG_PREFIX_16_23:  r_prefix[2*CFG_DATA_W +: CFG_DATA_W] <= i_cfg_wdata;
                CFG_PREFIX_24_31:  r_prefix[3*CFG_DATA_W +: CFG_DATA_W] <= i_cfg_wdata;
                CFG_MATCH_LIMIT:   r_limit <= i_cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;

    // prefix length clamp, current prefix byte, saturating offset
    assign plen      = (r_plen > MAX_PLEN) ? MAX_PLEN : r_plen;
    assign idx_ext   = PLEN_W'(r_idx);
    assign byte_sel  = BYTE_SEL_W'(r_idx);
    assign pbyte     = r_prefix[{byte_sel, 3'b000} +: BYTE_W];
    assign pos_inc   = (r_offset == '1) ? r_offset : r_offset + 1'b1;
    assign line_wide = {{OUT_OFF_W{1'b0}}, r_line};
    assign pos_wide  = {{OUT_OFF_W{1'b0}}, r_offset};

    // byte classification and state update
    always_comb begin
        n_offset = r_offset;
        n_line   = r_line;
        n_idx    = r_idx;
        n_still  = r_still;
        n_count  = r_count;
        n_ovf    = r_ovf;
        o_push   = 1'b0;
        o_event  = '0;

        if (accept) begin
            if (!r_ovf) begin
                // prefix complete: this byte is the one after it
                if (r_still && idx_ext >= plen) begin
                    o_push  = 1'b1;
                    n_still = 1'b0;
                    if (r_count < r_limit) begin
                        n_count              = r_count + 1'b1;
                        o_event.kind         = KIND_MATCH;
                        o_event.line_offset  = line_wide[OUT_OFF_W-1:0];
                        o_event.after_offset = pos_wide[OUT_OFF_W-1:0];
                        o_event.count        = n_count;
                    end else begin
                        n_ovf         = 1'b1;
                        o_event.kind  = KIND_OVERFLOW;
                        o_event.count = r_count;
                    end
                end

                if (!n_ovf) begin
                    if (i_dict_byte == NEWLINE_BYTE) begin
                        n_idx   = '0;
                        n_still = 1'b1;
                        n_line  = pos_inc;
                    end else if (n_still) begin
                        if (idx_ext < MAX_PLEN && i_dict_byte == pbyte) begin
                            n_idx = r_idx + 1'b1;
                        end else begin
                            n_still = 1'b0;
                        end
                    end
                    n_offset = pos_inc;

                    // done result on the last byte
                    if (i_final_byte) begin
                        if (o_push) begin
                            o_event.tail_done = 1'b1;
                        end else begin
                            o_push        = 1'b1;
                            o_event.kind  = KIND_DONE;
                            o_event.count = n_count;
                        end
                    end
                end
            end

            // last byte restarts the search
            if (i_final_byte) begin
                n_offset = '0;
                n_line   = '0;
                n_idx    = '0;
                n_still  = 1'b1;
                n_count  = '0;
                n_ovf    = 1'b0;
            end
        end
    end

    // search state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_line   <= '0;
            r_idx    <= '0;
            r_still  <= 1'b1;
            r_count  <= '0;
            r_ovf    <= 1'b0;
        end else begin
            r_offset <= n_offset;
            r_line   <= n_line;
            r_idx    <= n_idx;
            r_still  <= n_still;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
        end
    end

endmodule

/* hdl/lpm_queue.sv */
// ============================================================================
// lpm_queue
// Short queue of event records between the front end and the result side.
// ============================================================================
module lpm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lpm_pkg::t_event i_event,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output lpm_pkg::t_event o_head
);
    import lpm_pkg::*;

    t_event            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_event;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* hdl/lpm_back.sv */
// ============================================================================
// lpm_back
// Result side: unpacks each queued event into one or two result items and
// pops the entry once its last item has been taken.
// ============================================================================
module lpm_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  lpm_pkg::t_event   i_head,
    output logic              o_pop,
    lpm_result_if.source      o_result
);
    import lpm_pkg::*;

    logic r_phase, n_phase;   // 1 while the trailing done item is shown
    logic take;

    assign o_result.valid = !i_empty;
    assign take           = o_result.valid && o_result.ready;

    // output fields per phase
    always_comb begin
        if (r_phase) begin
            o_result.result_kind         = KIND_DONE;
            o_result.line_offset         = '0;
            o_result.after_prefix_offset = '0;
            o_result.last_of_run         = 1'b1;
        end else begin
            o_result.result_kind         = i_head.kind;
            o_result.line_offset         = i_head.line_offset;
            o_result.after_prefix_offset = i_head.after_offset;
            o_result.last_of_run         = !i_head.tail_done;
        end
        o_result.matches_found = i_head.count;
    end

    // phase advance and pop
    always_comb begin
        n_phase = r_phase;
        o_pop   = 1'b0;
        if (take) begin
            if (!r_phase && i_head.tail_done) begin
                n_phase = 1'b1;
            end else begin
                n_phase = 1'b0;
                o_pop   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
        end else begin
            r_phase <= n_phase;
        end
    end

endmodule
